>>> rtl/scbf_pkg.sv
package scbf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_CLASSES_DEF = 8;
  localparam int unsigned SIZE_BITS_DEF   = 20;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // The slot field is 3 bits wide, so at most eight slots can ever be loaded
  localparam int unsigned SLOT_BITS = 3;
  localparam int unsigned MAX_SLOTS = 2 ** SLOT_BITS;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } back_state_e;

endpackage

>>> rtl/size_class_best_fit_allocator.sv
// Channel   Direction  Transfer when      Payload
// input     in         push && !full      kind_i, class_slot_i, class_size_i,
//                                         class_count_i, request_size_i
// result    out        pop && !empty      granted_o, granted_size_o
//
// A load is written to the slot table by the back end once at the head of the command queue.
// A request is started, then scans the min(NUM_CLASSES, 8) class slots (one slot
// table read a cycle), then writes its result once the result register is free.
// Reset clears the slot table (all sizes and free counts zero) and both queues.
// Two commands queue ahead of the back end; a full result register stalls
// only the back end, the front keeps taking items until its queue fills.
module size_class_best_fit_allocator #(
  parameter int unsigned NUM_CLASSES = scbf_pkg::NUM_CLASSES_DEF,
  parameter int unsigned SIZE_BITS   = scbf_pkg::SIZE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = scbf_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input queue side
  input  logic                           push,
  output logic                           full,
  input  logic                           kind_i,
  input  logic [scbf_pkg::SLOT_BITS-1:0] class_slot_i,
  input  logic [SIZE_BITS-1:0]           class_size_i,
  input  logic [COUNT_BITS-1:0]          class_count_i,
  input  logic [SIZE_BITS-1:0]           request_size_i,
  // result queue side
  output logic                           empty,
  input  logic                           pop,
  output logic                           granted_o,
  output logic [SIZE_BITS-1:0]           granted_size_o
);

  // front -> back command
  logic                           cmd_valid, cmd_ready;
  scbf_pkg::kind_e                cmd_kind;
  logic [scbf_pkg::SLOT_BITS-1:0] cmd_slot;
  logic [SIZE_BITS-1:0]           cmd_value;
  logic [COUNT_BITS-1:0]          cmd_count;

  logic res_valid, res_pop;

  // Front end: accepts and classifies items into a short command queue
  scbf_front #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .kind_i         (kind_i),
    .class_slot_i   (class_slot_i),
    .class_size_i   (class_size_i),
    .class_count_i  (class_count_i),
    .request_size_i (request_size_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_kind_o     (cmd_kind),
    .cmd_slot_o     (cmd_slot),
    .cmd_value_o    (cmd_value),
    .cmd_count_o    (cmd_count)
  );

  // Back end: slot table, serial best-fit scan, result register
  scbf_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .SIZE_BITS   (SIZE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_kind_i     (cmd_kind),
    .cmd_slot_i     (cmd_slot),
    .cmd_value_i    (cmd_value),
    .cmd_count_i    (cmd_count),
    .res_pop_i      (res_pop),
    .res_valid_o    (res_valid),
    .granted_o      (granted_o),
    .granted_size_o (granted_size_o)
  );

  // a pop only counts while a result is held
  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

endmodule

>>> rtl/scbf_front.sv
module scbf_front #(
  parameter int unsigned SIZE_BITS  = scbf_pkg::SIZE_BITS_DEF,
  parameter int unsigned COUNT_BITS = scbf_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic                           kind_i,
  input  logic [scbf_pkg::SLOT_BITS-1:0] class_slot_i,
  input  logic [SIZE_BITS-1:0]           class_size_i,
  input  logic [COUNT_BITS-1:0]          class_count_i,
  input  logic [SIZE_BITS-1:0]           request_size_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output scbf_pkg::kind_e                cmd_kind_o,
  output logic [scbf_pkg::SLOT_BITS-1:0] cmd_slot_o,
  output logic [SIZE_BITS-1:0]           cmd_value_o,
  output logic [COUNT_BITS-1:0]          cmd_count_o
);

  localparam int unsigned Depth = scbf_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  scbf_pkg::kind_e                kind_q  [Depth];
  logic [scbf_pkg::SLOT_BITS-1:0] slot_q  [Depth];
  logic [SIZE_BITS-1:0]           value_q [Depth];
  logic [COUNT_BITS-1:0]          count_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            wr_en, rd_en;
  scbf_pkg::kind_e kind_in;

  assign kind_in = scbf_pkg::kind_e'(kind_i);
  assign full_o  = (fill_q == CntW'(Depth));
  assign wr_en   = push_i && !full_o;
  assign cmd_valid_o = (fill_q != '0);
  assign rd_en   = cmd_valid_o && cmd_ready_i;

  assign cmd_kind_o  = kind_q[rd_ptr_q];
  assign cmd_slot_o  = slot_q[rd_ptr_q];
  assign cmd_value_o = value_q[rd_ptr_q];
  assign cmd_count_o = count_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      fill_d = fill_q + CntW'(1);
    end else if (!wr_en && rd_en) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Classify on entry: a request carries its size in the value field
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      kind_q[wr_ptr_q]  <= kind_in;
      slot_q[wr_ptr_q]  <= class_slot_i;
      value_q[wr_ptr_q] <= (kind_in == scbf_pkg::KIND_REQUEST) ? request_size_i : class_size_i;
      count_q[wr_ptr_q] <= class_count_i;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= Depth)
    else $error("command queue over capacity");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !cmd_ready_i |=> fill_q == $past(fill_q))
    else $error("queue changed while full and stalled");

endmodule

>>> rtl/scbf_back.sv
module scbf_back #(
  parameter int unsigned NUM_CLASSES = scbf_pkg::NUM_CLASSES_DEF,
  parameter int unsigned SIZE_BITS   = scbf_pkg::SIZE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = scbf_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  scbf_pkg::kind_e                cmd_kind_i,
  input  logic [scbf_pkg::SLOT_BITS-1:0] cmd_slot_i,
  input  logic [SIZE_BITS-1:0]           cmd_value_i,
  input  logic [COUNT_BITS-1:0]          cmd_count_i,
  input  logic                           res_pop_i,
  output logic                           res_valid_o,
  output logic                           granted_o,
  output logic [SIZE_BITS-1:0]           granted_size_o
);

  // Only slots reachable through the slot field are stored
  localparam int unsigned NumSlots = (NUM_CLASSES < scbf_pkg::MAX_SLOTS) ?
                                     NUM_CLASSES : scbf_pkg::MAX_SLOTS;
  localparam int unsigned IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned SlotCmpW = scbf_pkg::SLOT_BITS + 1;

  logic [SIZE_BITS-1:0]  sizes_q  [NumSlots];
  logic [COUNT_BITS-1:0] counts_q [NumSlots];

  scbf_pkg::back_state_e state_q, state_d;
  logic [IdxW-1:0]      idx_q, idx_d, best_idx_q, best_idx_d;
  logic                 found_q, found_d;
  logic [SIZE_BITS-1:0] best_size_q, best_size_d, want_q, want_d;
  logic                 res_valid_q, granted_q;
  logic [SIZE_BITS-1:0] granted_size_q;

  logic                  load_we, dec_we, res_load, slot_ok, cand;
  logic [IdxW-1:0]       wr_idx;
  logic [SIZE_BITS-1:0]  cur_size;
  logic [COUNT_BITS-1:0] cur_count;

  assign slot_ok   = {1'b0, cmd_slot_i} < SlotCmpW'(NumSlots);
  assign wr_idx    = cmd_slot_i[IdxW-1:0];
  assign cur_size  = sizes_q[idx_q];
  assign cur_count = counts_q[idx_q];
  // smaller fitting nonempty class; ties keep the lower slot
  assign cand = (cur_count != '0) && (cur_size >= want_q) &&
                (!found_q || (cur_size < best_size_q));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    found_d     = found_q;
    best_size_d = best_size_q;
    want_d      = want_q;
    cmd_ready_o = 1'b0;
    load_we     = 1'b0;
    dec_we      = 1'b0;
    res_load    = 1'b0;
    unique case (state_q)
      scbf_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_kind_i == scbf_pkg::KIND_LOAD) begin
            load_we = slot_ok;
          end else begin
            want_d  = cmd_value_i;
            idx_d   = '0;
            found_d = 1'b0;
            state_d = scbf_pkg::ST_SCAN;
          end
        end
      end
      scbf_pkg::ST_SCAN: begin
        if (cand) begin
          found_d     = 1'b1;
          best_idx_d  = idx_q;
          best_size_d = cur_size;
        end
        if (idx_q == IdxW'(NumSlots - 1)) begin
          state_d = scbf_pkg::ST_FINISH;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      scbf_pkg::ST_FINISH: begin
        if (!res_valid_q || res_pop_i) begin
          res_load = 1'b1;
          dec_we   = found_q;
          state_d  = scbf_pkg::ST_IDLE;
        end
      end
      default: state_d = scbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scbf_pkg::ST_IDLE;
      idx_q       <= '0;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      sizes_q     <= '{default: '0};
      counts_q    <= '{default: '0};
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      best_idx_q <= best_idx_d;
      found_q    <= found_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      if (load_we) begin
        sizes_q[wr_idx]  <= cmd_value_i;
        counts_q[wr_idx] <= cmd_count_i;
      end else if (dec_we) begin
        counts_q[best_idx_q] <= counts_q[best_idx_q] - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    want_q      <= want_d;
    best_size_q <= best_size_d;
    if (res_load) begin
      granted_q      <= found_q;
      granted_size_q <= found_q ? best_size_q : '0;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign granted_o      = granted_q;
  assign granted_size_o = granted_size_q;

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == scbf_pkg::ST_FINISH)
    else $error("result appeared outside finish");

  a_fail_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !granted_q |-> granted_size_q == '0)
    else $error("failed request with nonzero size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scbf_pkg::ST_SCAN |-> 32'(idx_q) < NumSlots)
    else $error("scan index past last slot");

endmodule
